// ===== src/ttfs_pkg.sv =====
// Shared types and codes of the thread-slot scheduler.
package ttfs_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W = 2;
	localparam int ID_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_YIELD  = 2'd1,
		CMD_SCHED  = 2'd2,
		CMD_EXIT   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_BAD_TARGET = 2'd2,
		ST_NO_THREAD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [ID_W-1:0]          target;
		logic [WORD_W-1:0]        entry_addr;
		logic signed [WORD_W-1:0] entry_param;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [ID_W-1:0]          result_id;
		logic [ID_W-1:0]          running_id;
		logic                     first_dispatch;
		logic [WORD_W-1:0]        start_addr;
		logic signed [WORD_W-1:0] start_param;
	} rsp_t;

	// Controls of the shared minimum-stamp compare unit.
	typedef struct packed {
		logic clear;
		logic step;
		logic cand;
	} scan_ctl_t;

endpackage

// ===== src/ttfs_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface ttfs_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/thread_table_fifo_scheduler.sv =====
// Thread-slot manager: create, yield, schedule and exit over a table of hardware thread slots.
// One command is in work at a time; req.ready is high only while the sequencer is idle, and a
// finished response may wait in the output register while the next command is taken. A create
// runs a next-fit search that tests one slot per cycle; a yield passes through dispatch, or goes
// straight to the response when the target is refused. Schedule and exit dispatch only when
// they switch threads: every slot's stamp is first read through the single read port of the
// stamp memory, one slot per cycle, and fed to one shared compare unit that keeps the oldest
// queued thread. The next command can be taken as soon as the response is presented, and
// later only if an earlier response is still waiting.
module thread_table_fifo_scheduler #(
	parameter int THREAD_SLOTS = 16,
	parameter int STAMP_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	ttfs_chan_if.sink   req,
	ttfs_chan_if.source rsp
);
	localparam int IDX_W = $clog2(THREAD_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_SLOTS - 1);
	localparam int WORD_W = ttfs_pkg::WORD_W;
	localparam int PAY_W = 2 * WORD_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_SCAN,
		S_DRAIN,
		S_PICK,
		S_DISPATCH,
		S_LOAD,
		S_OUT
	} state_t;

	state_t                      state_q;
	logic [ttfs_pkg::CMD_W-1:0]  cmd_q;
	logic [ttfs_pkg::ID_W-1:0]   target_q;
	logic [WORD_W-1:0]           addr_q;
	logic [WORD_W-1:0]           param_q;
	logic [THREAD_SLOTS-1:0]     valid_q;
	logic [THREAD_SLOTS-1:0]     fresh_q;
	logic [IDX_W-1:0]            run_q;
	logic [IDX_W-1:0]            last_q;
	logic [STAMP_BITS-1:0]       cnt_q;
	logic [IDX_W-1:0]            ptr_q;
	logic [IDX_W-1:0]            tries_q;
	logic [IDX_W-1:0]            tgt_q;
	ttfs_pkg::status_t           status_q;
	logic [IDX_W-1:0]            rid_q;
	logic                        first_q;
	logic [WORD_W-1:0]           saddr_q;
	logic [WORD_W-1:0]           sparam_q;
	logic                        rsp_valid_q;
	ttfs_pkg::rsp_t              rsp_data_q;
	logic                        stamp0_zero_q;
	logic                        step_s1;
	logic                        cand_s1;
	logic [IDX_W-1:0]            idx_s1;

	logic                        st_we;
	logic [IDX_W-1:0]            st_waddr;
	logic [STAMP_BITS-1:0]       st_rdata;
	logic [STAMP_BITS-1:0]       stamp_rd;
	logic                        pay_we;
	logic [PAY_W-1:0]            pay_rdata;
	logic [STAMP_BITS-1:0]       cnt_next;
	logic                        free_here;
	logic                        tgt_ok;
	logic [IDX_W-1:0]            tgt_idx;
	ttfs_pkg::scan_ctl_t         scan_ctl;
	logic                        found;
	logic [IDX_W-1:0]            pick;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
		logic [IDX_W-1:0] r;
		if (x == LAST_IDX) begin
			r = '0;
		end else begin
			r = x + 1'b1;
		end
		return r;
	endfunction

	// The stamp counter sticks at its top value once reached.
	assign cnt_next  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign free_here = !valid_q[ptr_q];
	assign tgt_idx   = IDX_W'(target_q);
	assign tgt_ok    = (32'(target_q) < 32'(THREAD_SLOTS)) && valid_q[tgt_idx];

	assign st_we    = ((state_q == S_FIND) && free_here) ||
	                  ((state_q == S_DISPATCH) && valid_q[run_q]);
	assign st_waddr = (state_q == S_FIND) ? ptr_q : run_q;
	assign pay_we   = (state_q == S_FIND) && free_here;

	ttfs_ram #(
		.DEPTH (THREAD_SLOTS),
		.WIDTH (STAMP_BITS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (cnt_q),
		.re    (state_q == S_SCAN),
		.raddr (ptr_q),
		.rdata (st_rdata)
	);

	ttfs_ram #(
		.DEPTH (THREAD_SLOTS),
		.WIDTH (PAY_W)
	) u_entry_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (ptr_q),
		.wdata ({addr_q, param_q}),
		.re    (state_q == S_DISPATCH),
		.raddr (tgt_q),
		.rdata (pay_rdata)
	);

	// Slot 0 is live from reset with a zero stamp that was never written to the memory.
	assign stamp_rd = ((idx_s1 == '0) && stamp0_zero_q) ? '0 : st_rdata;

	assign scan_ctl.clear = (state_q == S_DECODE);
	assign scan_ctl.step  = step_s1;
	assign scan_ctl.cand  = cand_s1;

	ttfs_min_unit #(
		.IDX_W      (IDX_W),
		.STAMP_BITS (STAMP_BITS)
	) u_min_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (idx_s1),
		.stamp  (stamp_rd),
		.found  (found),
		.pick   (pick)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= THREAD_SLOTS'(1);
			fresh_q       <= '0;
			run_q         <= '0;
			last_q        <= '0;
			cnt_q         <= STAMP_BITS'(1);
			stamp0_zero_q <= 1'b1;
			rsp_valid_q   <= 1'b0;
			step_s1       <= 1'b0;
		end else begin
			step_s1 <= (state_q == S_SCAN);
			cand_s1 <= valid_q[ptr_q] && (ptr_q != run_q);
			idx_s1  <= ptr_q;
			if (st_we && (st_waddr == '0)) begin
				stamp0_zero_q <= 1'b0;
			end
			// In S_OUT the output register is reloaded or held by the state itself.
			if (rsp.ready && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.data.cmd;
						target_q <= req.data.target;
						addr_q   <= req.data.entry_addr;
						param_q  <= req.data.entry_param;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					rid_q    <= '0;
					first_q  <= 1'b0;
					saddr_q  <= '0;
					sparam_q <= '0;
					tries_q  <= '0;
					case (cmd_q)
						ttfs_pkg::CMD_CREATE: begin
							status_q <= ttfs_pkg::ST_OK;
							ptr_q    <= next_idx(last_q);
							state_q  <= S_FIND;
						end
						ttfs_pkg::CMD_YIELD: begin
							ptr_q <= '0;
							if (tgt_ok) begin
								status_q <= ttfs_pkg::ST_OK;
								tgt_q    <= tgt_idx;
								state_q  <= S_DISPATCH;
							end else begin
								status_q <= ttfs_pkg::ST_BAD_TARGET;
								state_q  <= S_OUT;
							end
						end
						ttfs_pkg::CMD_SCHED: begin
							status_q <= ttfs_pkg::ST_OK;
							ptr_q    <= '0;
							state_q  <= S_SCAN;
						end
						ttfs_pkg::CMD_EXIT: begin
							status_q       <= ttfs_pkg::ST_OK;
							ptr_q          <= '0;
							valid_q[run_q] <= 1'b0;
							fresh_q[run_q] <= 1'b0;
							state_q        <= S_SCAN;
						end
						default: begin
							status_q <= ttfs_pkg::ST_OK;
							ptr_q    <= '0;
							state_q  <= S_SCAN;
						end
					endcase
				end
				S_FIND: begin
					if (free_here) begin
						valid_q[ptr_q] <= 1'b1;
						fresh_q[ptr_q] <= 1'b1;
						last_q         <= ptr_q;
						cnt_q          <= cnt_next;
						rid_q          <= ptr_q;
						state_q        <= S_OUT;
					end else if (tries_q == LAST_IDX) begin
						status_q <= ttfs_pkg::ST_FULL;
						state_q  <= S_OUT;
					end else begin
						ptr_q   <= next_idx(ptr_q);
						tries_q <= tries_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (ptr_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (found) begin
						tgt_q   <= pick;
						state_q <= S_DISPATCH;
					end else if (valid_q[run_q]) begin
						rid_q   <= run_q;
						state_q <= S_OUT;
					end else begin
						status_q <= ttfs_pkg::ST_NO_THREAD;
						state_q  <= S_OUT;
					end
				end
				S_DISPATCH: begin
					// The caller is re-queued behind everything stamped so far.
					if (valid_q[run_q]) begin
						cnt_q <= cnt_next;
					end
					rid_q          <= run_q;
					run_q          <= tgt_q;
					first_q        <= fresh_q[tgt_q];
					fresh_q[tgt_q] <= 1'b0;
					state_q        <= S_LOAD;
				end
				S_LOAD: begin
					saddr_q  <= first_q ? pay_rdata[PAY_W-1:WORD_W] : '0;
					sparam_q <= first_q ? pay_rdata[WORD_W-1:0] : '0;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q                <= 1'b1;
						rsp_data_q.status          <= status_q;
						rsp_data_q.result_id       <= ttfs_pkg::ID_W'(rid_q);
						rsp_data_q.running_id      <= ttfs_pkg::ID_W'(run_q);
						rsp_data_q.first_dispatch  <= first_q;
						rsp_data_q.start_addr      <= saddr_q;
						rsp_data_q.start_param     <= sparam_q;
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_stamp_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("stamp counter went backwards");

	a_pick_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) && found |-> valid_q[pick] && (pick != run_q))
		else $error("scheduler picked a free or running slot");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) && !free_here && (tries_q == LAST_IDX) |-> (&valid_q))
		else $error("table reported full with a free slot");

	a_first_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.first_dispatch |-> (rsp_data_q.status == ttfs_pkg::ST_OK))
		else $error("first dispatch reported with an error status");

endmodule

// ===== src/ttfs_ram.sv =====
// Single-write, single-read memory with registered read data.
module ttfs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== src/ttfs_min_unit.sv =====
// Shared compare unit: keeps the oldest stamp seen over a scan of the slots.
module ttfs_min_unit #(
	parameter int IDX_W = 4,
	parameter int STAMP_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ttfs_pkg::scan_ctl_t     ctl,
	input  logic [IDX_W-1:0]        idx,
	input  logic [STAMP_BITS-1:0]   stamp,
	output logic                    found,
	output logic [IDX_W-1:0]        pick
);
	logic                  have_q;
	logic [STAMP_BITS-1:0] best_q;
	logic [IDX_W-1:0]      pick_q;
	logic                  take;

	// Slots arrive in ascending order, so a strict compare leaves ties with the lowest index.
	assign take = ctl.step && ctl.cand && (!have_q || (stamp < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= stamp;
			pick_q <= idx;
		end
	end

	assign found = have_q;
	assign pick  = pick_q;
endmodule
